### design/nearest_palette_color_search_core_defines.svh
// assertion macros used by the checker file
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define NPCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define NPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/npcs_pkg.sv
package npcs_pkg;

    localparam int PaletteSizeDefault = 256;
    localparam int DefaultEntries     = 256;
    localparam int ChanW              = 8;
    localparam int ColorW             = 3 * ChanW;
    localparam int SqW                = 2 * ChanW;
    localparam int DistW              = 18;
    localparam int IdxOutW            = 8;
    localparam int InDataW            = 32;
    localparam int OutDataW           = 32;
    localparam int OutPadW            = OutDataW - IdxOutW - DistW;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } func_t;

    // travels with each palette read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

    // power-on palette, red in the high byte
    localparam logic [ColorW-1:0] DEFAULT_PALETTE [DefaultEntries] = '{
        {8'd0,8'd0,8'd0}, {8'd0,8'd2,8'd170}, {8'd20,8'd170,8'd0}, {8'd0,8'd170,8'd170},
        {8'd170,8'd0,8'd3}, {8'd170,8'd0,8'd170}, {8'd170,8'd85,8'd0},
        {8'd170,8'd170,8'd170}, {8'd85,8'd85,8'd85}, {8'd85,8'd85,8'd255},
        {8'd85,8'd255,8'd85}, {8'd85,8'd255,8'd255}, {8'd255,8'd85,8'd85},
        {8'd253,8'd85,8'd255}, {8'd255,8'd255,8'd85}, {8'd255,8'd255,8'd255},
        {8'd0,8'd0,8'd0}, {8'd16,8'd16,8'd16}, {8'd32,8'd32,8'd32}, {8'd53,8'd53,8'd53},
        {8'd69,8'd69,8'd69}, {8'd85,8'd85,8'd85}, {8'd101,8'd101,8'd101},
        {8'd117,8'd117,8'd117}, {8'd138,8'd138,8'd138}, {8'd154,8'd154,8'd154},
        {8'd170,8'd170,8'd170}, {8'd186,8'd186,8'd186}, {8'd202,8'd202,8'd202},
        {8'd223,8'd223,8'd223}, {8'd239,8'd239,8'd239}, {8'd255,8'd255,8'd255},
        {8'd0,8'd4,8'd255}, {8'd65,8'd4,8'd255}, {8'd130,8'd3,8'd255},
        {8'd190,8'd2,8'd255}, {8'd253,8'd0,8'd255}, {8'd254,8'd0,8'd190},
        {8'd255,8'd0,8'd130}, {8'd255,8'd0,8'd65}, {8'd255,8'd0,8'd8},
        {8'd255,8'd65,8'd5}, {8'd255,8'd130,8'd0}, {8'd255,8'd190,8'd0},
        {8'd255,8'd255,8'd0}, {8'd190,8'd255,8'd0}, {8'd130,8'd255,8'd0},
        {8'd65,8'd255,8'd1}, {8'd36,8'd255,8'd0}, {8'd34,8'd255,8'd66},
        {8'd29,8'd255,8'd130}, {8'd18,8'd255,8'd190}, {8'd0,8'd255,8'd255},
        {8'd0,8'd190,8'd255}, {8'd1,8'd130,8'd255}, {8'd0,8'd65,8'd255},
        {8'd130,8'd130,8'd255}, {8'd158,8'd130,8'd255}, {8'd190,8'd130,8'd255},
        {8'd223,8'd130,8'd255}, {8'd253,8'd130,8'd255}, {8'd254,8'd130,8'd223},
        {8'd255,8'd130,8'd190}, {8'd255,8'd130,8'd158}, {8'd255,8'd130,8'd130},
        {8'd255,8'd158,8'd130}, {8'd255,8'd190,8'd130}, {8'd255,8'd223,8'd130},
        {8'd255,8'd255,8'd130}, {8'd223,8'd255,8'd130}, {8'd190,8'd255,8'd130},
        {8'd158,8'd255,8'd130}, {8'd130,8'd255,8'd130}, {8'd130,8'd255,8'd158},
        {8'd130,8'd255,8'd190}, {8'd130,8'd255,8'd223}, {8'd130,8'd255,8'd255},
        {8'd130,8'd223,8'd255}, {8'd130,8'd190,8'd255}, {8'd130,8'd158,8'd255},
        {8'd186,8'd186,8'd255}, {8'd202,8'd186,8'd255}, {8'd223,8'd186,8'd255},
        {8'd239,8'd186,8'd255}, {8'd254,8'd186,8'd255}, {8'd254,8'd186,8'd239},
        {8'd255,8'd186,8'd223}, {8'd255,8'd186,8'd202}, {8'd255,8'd186,8'd186},
        {8'd255,8'd202,8'd186}, {8'd255,8'd223,8'd186}, {8'd255,8'd239,8'd186},
        {8'd255,8'd255,8'd186}, {8'd239,8'd255,8'd186}, {8'd223,8'd255,8'd186},
        {8'd202,8'd255,8'd187}, {8'd186,8'd255,8'd186}, {8'd186,8'd255,8'd202},
        {8'd186,8'd255,8'd223}, {8'd186,8'd255,8'd239}, {8'd186,8'd255,8'd255},
        {8'd186,8'd239,8'd255}, {8'd186,8'd223,8'd255}, {8'd186,8'd202,8'd255},
        {8'd1,8'd1,8'd113}, {8'd28,8'd1,8'd113}, {8'd57,8'd1,8'd113},
        {8'd85,8'd0,8'd113}, {8'd113,8'd0,8'd113}, {8'd113,8'd0,8'd85},
        {8'd113,8'd0,8'd57}, {8'd113,8'd0,8'd28}, {8'd113,8'd0,8'd1},
        {8'd113,8'd28,8'd1}, {8'd113,8'd57,8'd0}, {8'd113,8'd85,8'd0},
        {8'd113,8'd113,8'd0}, {8'd85,8'd113,8'd0}, {8'd57,8'd113,8'd0},
        {8'd28,8'd113,8'd0}, {8'd9,8'd113,8'd0}, {8'd9,8'd113,8'd28},
        {8'd6,8'd113,8'd57}, {8'd3,8'd113,8'd85}, {8'd0,8'd113,8'd113},
        {8'd0,8'd85,8'd113}, {8'd0,8'd57,8'd113}, {8'd0,8'd28,8'd113},
        {8'd57,8'd57,8'd113}, {8'd69,8'd57,8'd113}, {8'd85,8'd57,8'd113},
        {8'd97,8'd57,8'd113}, {8'd113,8'd57,8'd113}, {8'd113,8'd57,8'd97},
        {8'd113,8'd57,8'd85}, {8'd113,8'd57,8'd69}, {8'd113,8'd57,8'd57},
        {8'd113,8'd69,8'd57}, {8'd113,8'd85,8'd57}, {8'd113,8'd97,8'd57},
        {8'd113,8'd113,8'd57}, {8'd97,8'd113,8'd57}, {8'd85,8'd113,8'd57},
        {8'd69,8'd113,8'd58}, {8'd57,8'd113,8'd57}, {8'd57,8'd113,8'd69},
        {8'd57,8'd113,8'd85}, {8'd57,8'd113,8'd97}, {8'd57,8'd113,8'd113},
        {8'd57,8'd97,8'd113}, {8'd57,8'd85,8'd113}, {8'd57,8'd69,8'd114},
        {8'd81,8'd81,8'd113}, {8'd89,8'd81,8'd113}, {8'd97,8'd81,8'd113},
        {8'd105,8'd81,8'd113}, {8'd113,8'd81,8'd113}, {8'd113,8'd81,8'd105},
        {8'd113,8'd81,8'd97}, {8'd113,8'd81,8'd89}, {8'd113,8'd81,8'd81},
        {8'd113,8'd89,8'd81}, {8'd113,8'd97,8'd81}, {8'd113,8'd105,8'd81},
        {8'd113,8'd113,8'd81}, {8'd105,8'd113,8'd81}, {8'd97,8'd113,8'd81},
        {8'd89,8'd113,8'd81}, {8'd81,8'd113,8'd81}, {8'd81,8'd113,8'd90},
        {8'd81,8'd113,8'd97}, {8'd81,8'd113,8'd105}, {8'd81,8'd113,8'd113},
        {8'd81,8'd105,8'd113}, {8'd81,8'd97,8'd113}, {8'd81,8'd89,8'd113},
        {8'd0,8'd0,8'd66}, {8'd17,8'd0,8'd65}, {8'd32,8'd0,8'd65},
        {8'd49,8'd0,8'd65}, {8'd65,8'd0,8'd65}, {8'd65,8'd0,8'd50},
        {8'd65,8'd0,8'd32}, {8'd65,8'd0,8'd16}, {8'd65,8'd0,8'd0},
        {8'd65,8'd16,8'd0}, {8'd65,8'd32,8'd0}, {8'd65,8'd49,8'd0},
        {8'd65,8'd65,8'd0}, {8'd49,8'd65,8'd0}, {8'd32,8'd65,8'd0},
        {8'd16,8'd65,8'd0}, {8'd3,8'd65,8'd0}, {8'd3,8'd65,8'd16},
        {8'd2,8'd65,8'd32}, {8'd1,8'd65,8'd49}, {8'd0,8'd65,8'd65},
        {8'd0,8'd49,8'd65}, {8'd0,8'd32,8'd65}, {8'd0,8'd16,8'd65},
        {8'd32,8'd32,8'd65}, {8'd40,8'd32,8'd65}, {8'd49,8'd32,8'd65},
        {8'd57,8'd32,8'd65}, {8'd65,8'd32,8'd65}, {8'd65,8'd32,8'd57},
        {8'd65,8'd32,8'd49}, {8'd65,8'd32,8'd40}, {8'd65,8'd32,8'd32},
        {8'd65,8'd40,8'd32}, {8'd65,8'd49,8'd32}, {8'd65,8'd57,8'd33},
        {8'd65,8'd65,8'd32}, {8'd57,8'd65,8'd32}, {8'd49,8'd65,8'd32},
        {8'd40,8'd65,8'd32}, {8'd32,8'd65,8'd32}, {8'd32,8'd65,8'd40},
        {8'd32,8'd65,8'd49}, {8'd32,8'd65,8'd57}, {8'd32,8'd65,8'd65},
        {8'd32,8'd57,8'd65}, {8'd32,8'd49,8'd65}, {8'd32,8'd40,8'd65},
        {8'd45,8'd45,8'd65}, {8'd49,8'd45,8'd65}, {8'd53,8'd45,8'd65},
        {8'd61,8'd45,8'd65}, {8'd65,8'd45,8'd65}, {8'd65,8'd45,8'd61},
        {8'd65,8'd45,8'd53}, {8'd65,8'd45,8'd49}, {8'd65,8'd45,8'd45},
        {8'd65,8'd49,8'd45}, {8'd65,8'd53,8'd45}, {8'd65,8'd61,8'd45},
        {8'd65,8'd65,8'd45}, {8'd61,8'd65,8'd45}, {8'd53,8'd65,8'd45},
        {8'd49,8'd65,8'd45}, {8'd45,8'd65,8'd45}, {8'd45,8'd65,8'd49},
        {8'd45,8'd65,8'd53}, {8'd45,8'd65,8'd61}, {8'd45,8'd65,8'd65},
        {8'd45,8'd61,8'd65}, {8'd45,8'd53,8'd65}, {8'd45,8'd49,8'd65},
        {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd0},
        {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd0}, {8'd0,8'd0,8'd0}
    };

endpackage

### design/npcs_dist.sv
module npcs_dist #(
    parameter int AW = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [npcs_pkg::ColorW-1:0]      pixel,
    input  logic [npcs_pkg::ColorW-1:0]      entry,
    input  npcs_pkg::scan_tag_t              tag_in,
    input  logic [AW-1:0]                    idx_in,
    output npcs_pkg::scan_tag_t              tag_out,
    output logic [AW-1:0]                    idx_out,
    output logic [npcs_pkg::DistW-1:0]       dist_sum
);
    import npcs_pkg::*;

    logic [ChanW-1:0] dr, dg, db;
    logic [SqW-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    scan_tag_t        tag_reg;
    logic [AW-1:0]    idx_reg;

    function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                  input logic [ChanW-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign dr = abs_diff(pixel[3*ChanW-1:2*ChanW], entry[3*ChanW-1:2*ChanW]);
    assign dg = abs_diff(pixel[2*ChanW-1:ChanW],   entry[2*ChanW-1:ChanW]);
    assign db = abs_diff(pixel[ChanW-1:0],         entry[ChanW-1:0]);

    // squares registered, sum taken on the far side
    always_ff @(posedge clk)
    begin
        sq_r_reg <= SqW'(dr) * SqW'(dr);
        sq_g_reg <= SqW'(dg) * SqW'(dg);
        sq_b_reg <= SqW'(db) * SqW'(db);
        idx_reg  <= idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out  = tag_reg;
    assign idx_out  = idx_reg;
    assign dist_sum = DistW'(sq_r_reg) + DistW'(sq_g_reg) + DistW'(sq_b_reg);

endmodule

### design/nearest_palette_color_search_core.sv
// channel     dir  fields (lowest bit up)                              transaction
// s_axis      in   tuser: func; tdata: entry_index, red, green, blue   write or query
// m_axis      out  tdata: closest_index, min_distance, zero pad        query result
//
// after reset the palette is loaded from the default table, one entry per cycle,
// with s_axis_tready low until every entry is written
// a palette write is stored in the cycle it is accepted; a query reads one palette
// entry per cycle from the one-read one-write memory, then passes the read, squares,
// minimum and output registers; one item is in progress at a time
// a result waiting on m_axis stalls only the final handoff of the next query
module nearest_palette_color_search_core #(
    parameter int PALETTE_SIZE = npcs_pkg::PaletteSizeDefault
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [npcs_pkg::InDataW-1:0]     s_axis_tdata,
    // func[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // closest_index[7:0], min_distance[25:8], zero[31:26]
    output logic [npcs_pkg::OutDataW-1:0]    m_axis_tdata
);
    import npcs_pkg::*;

    localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_SIZE - 1);

    // control
    state_t           state_reg, state_next;
    logic [AW-1:0]    init_cnt_reg, init_cnt_next;
    logic [AW-1:0]    scan_cnt_reg, scan_cnt_next;
    scan_tag_t        issue_tag, rd_tag_reg, sq_tag;
    logic             fin_reg;
    logic             out_valid_reg;
    logic             out_load;

    // palette memory and read side
    logic [ColorW-1:0] palette_mem [PALETTE_SIZE];
    logic [ColorW-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [ColorW-1:0] mem_wdata;
    logic [AW-1:0]     rd_idx_reg;
    logic [AW-1:0]     sq_idx;
    logic [DistW-1:0]  sq_dist;

    // payload
    logic [ColorW-1:0]   pix_reg;
    logic [AW-1:0]       best_idx_reg;
    logic [DistW-1:0]    best_dist_reg;
    logic [OutDataW-1:0] out_data_reg;

    // input field decode
    logic              s_accept;
    func_t             in_func;
    logic [ChanW-1:0]  in_index;
    logic [ColorW-1:0] in_color;
    logic [31:0]       wr_idx32;
    logic              wr_in_range;
    logic [31:0]       init_idx32;
    logic [ColorW-1:0] init_color;
    logic [31:0]       best_idx32;

    assign s_accept    = s_axis_tvalid && s_axis_tready;
    assign in_func     = func_t'(s_axis_tuser[0]);
    assign in_index    = s_axis_tdata[ChanW-1:0];
    // memory word keeps red on top
    assign in_color    = {s_axis_tdata[2*ChanW-1:ChanW],
                          s_axis_tdata[3*ChanW-1:2*ChanW],
                          s_axis_tdata[4*ChanW-1:3*ChanW]};
    assign wr_idx32    = 32'(in_index);
    assign wr_in_range = (wr_idx32 < 32'(PALETTE_SIZE));

    // entries past the default table come up black
    assign init_idx32  = 32'(init_cnt_reg);
    assign init_color  = (init_idx32 < 32'(DefaultEntries)) ?
                         DEFAULT_PALETTE[init_idx32[7:0]] : '0;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // sequencer: init sweep, idle, scan issue, flush and handoff
    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        scan_cnt_next = scan_cnt_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        issue_tag     = '0;
        out_load      = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = init_color;
                if (init_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_func == FUNC_QUERY)
                    begin
                        state_next    = ST_SCAN;
                        scan_cnt_next = '0;
                    end
                    else if (wr_in_range)
                    begin
                        // out-of-range writes are dropped
                        mem_we    = 1'b1;
                        mem_waddr = wr_idx32[AW-1:0];
                        mem_wdata = in_color;
                    end
                end
            end
            ST_SCAN:
            begin
                issue_tag.valid = 1'b1;
                issue_tag.first = (scan_cnt_reg == '0);
                issue_tag.last  = (scan_cnt_reg == LAST_ADDR);
                if (scan_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                // wait for the last compare, then for room in the output register
                if (fin_reg && (!out_valid_reg || m_axis_tready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            scan_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            scan_cnt_reg <= scan_cnt_next;
        end
    end

    // palette memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= palette_mem[scan_cnt_reg];
        rd_idx_reg    <= scan_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
        end
        else
        begin
            rd_tag_reg <= issue_tag;
        end
    end

    // query pixel held for the whole scan
    always_ff @(posedge clk)
    begin
        if (s_accept && (in_func == FUNC_QUERY))
        begin
            pix_reg <= in_color;
        end
    end

    npcs_dist #(
        .AW (AW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pix_reg),
        .entry    (mem_rdata_reg),
        .tag_in   (rd_tag_reg),
        .idx_in   (rd_idx_reg),
        .tag_out  (sq_tag),
        .idx_out  (sq_idx),
        .dist_sum (sq_dist)
    );

    // running minimum, strict less-than keeps the lowest index on a tie
    always_ff @(posedge clk)
    begin
        if (sq_tag.valid && (sq_tag.first || (sq_dist < best_dist_reg)))
        begin
            best_dist_reg <= sq_dist;
            best_idx_reg  <= sq_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= 1'b0;
        end
        else if (sq_tag.valid && sq_tag.last)
        begin
            fin_reg <= 1'b1;
        end
        else if (out_load)
        begin
            fin_reg <= 1'b0;
        end
    end

    // output register; index reported modulo 256
    assign best_idx32 = 32'(best_idx_reg);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {{OutPadW{1'b0}}, best_dist_reg, best_idx32[IdxOutW-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### design/npcs_checker.sv
`include "nearest_palette_color_search_core_defines.svh"

module npcs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [npcs_pkg::InDataW-1:0]     s_axis_tdata,
    input logic [0:0]                       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [npcs_pkg::OutDataW-1:0]    m_axis_tdata
);
    import npcs_pkg::*;

    // stalled result keeps its value
    `NPCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // distance never exceeds three full-scale squares
    `NPCS_ASSERT_NOW(a_dist_range, m_axis_tvalid, m_axis_tdata[25:8] <= 18'd195075, "distance out of range")

    `NPCS_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:26] == 6'd0, "pad bits not zero")

    // no result can appear right after any input transaction
    `NPCS_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result too early")

    // a query holds off further input while it scans
    `NPCS_ASSERT_NEXT(a_query_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready, "input taken during scan")

endmodule

bind nearest_palette_color_search_core npcs_checker u_npcs_checker (.*);
